/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers used by the alu checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assertion that is switched off while reset is asserted (active low)
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// assertion that is checked at every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

/* sv/ialu_pkg.sv */
// ----------------------------------------------------------------------------
// ialu_pkg
// shared constants, operation codes and stage-advance struct of the alu
// ----------------------------------------------------------------------------
package ialu_pkg;

    localparam int WORD_W  = 32;
    localparam int HALF_W  = WORD_W / 2;
    localparam int PROD_W  = 2 * WORD_W;
    localparam int CMD_W   = 5;
    localparam int SHAMT_W = 5;

    localparam logic [CMD_W-1:0] CMD_NOP   = 5'd0;
    localparam logic [CMD_W-1:0] CMD_SLL   = 5'd1;
    localparam logic [CMD_W-1:0] CMD_SRL   = 5'd2;
    localparam logic [CMD_W-1:0] CMD_SRA   = 5'd3;
    localparam logic [CMD_W-1:0] CMD_SEQ   = 5'd4;
    localparam logic [CMD_W-1:0] CMD_SNE   = 5'd5;
    localparam logic [CMD_W-1:0] CMD_SLT   = 5'd6;
    localparam logic [CMD_W-1:0] CMD_SLTU  = 5'd7;
    localparam logic [CMD_W-1:0] CMD_LUI   = 5'd8;
    localparam logic [CMD_W-1:0] CMD_NOR   = 5'd9;
    localparam logic [CMD_W-1:0] CMD_AND   = 5'd10;
    localparam logic [CMD_W-1:0] CMD_OR    = 5'd11;
    localparam logic [CMD_W-1:0] CMD_XOR   = 5'd12;
    localparam logic [CMD_W-1:0] CMD_NAND  = 5'd13;
    localparam logic [CMD_W-1:0] CMD_CLR   = 5'd14;
    localparam logic [CMD_W-1:0] CMD_ORC   = 5'd15;
    localparam logic [CMD_W-1:0] CMD_RSUB  = 5'd16;
    localparam logic [CMD_W-1:0] CMD_ADD   = 5'd17;
    localparam logic [CMD_W-1:0] CMD_SUB   = 5'd18;
    localparam logic [CMD_W-1:0] CMD_MULHI = 5'd19;
    localparam logic [CMD_W-1:0] CMD_MULLO = 5'd20;

    // load enables of the multiplier stages
    typedef struct packed {
        logic s2;
        logic s3;
    } t_ialu_adv;

endpackage

/* sv/ialu_exec.sv */
// ----------------------------------------------------------------------------
// ialu_exec
// combinational logic, shift, compare, load-upper and add/subtract datapath
// ----------------------------------------------------------------------------
module ialu_exec import ialu_pkg::*; (
    input  logic [CMD_W-1:0]  i_command,
    input  logic [WORD_W-1:0] i_operand_a,
    input  logic [WORD_W-1:0] i_operand_b,
    output logic [WORD_W-1:0] o_result
);

    logic [SHAMT_W-1:0] shamt;

    assign shamt = i_operand_b[SHAMT_W-1:0];

    always_comb begin
        unique case (i_command)
            CMD_SLL:  o_result = i_operand_a << shamt;
            CMD_SRL:  o_result = i_operand_a >> shamt;
            CMD_SRA:  o_result = $unsigned($signed(i_operand_a) >>> shamt);
            CMD_SEQ:  o_result = {{(WORD_W-1){1'b0}}, i_operand_a == i_operand_b};
            CMD_SNE:  o_result = {{(WORD_W-1){1'b0}}, i_operand_a != i_operand_b};
            CMD_SLT:  o_result = {{(WORD_W-1){1'b0}},
                                  $signed(i_operand_a) < $signed(i_operand_b)};
            CMD_SLTU: o_result = {{(WORD_W-1){1'b0}}, i_operand_a < i_operand_b};
            CMD_LUI:  o_result = {i_operand_a[HALF_W-1:0], {HALF_W{1'b0}}};
            CMD_NOR:  o_result = ~(i_operand_a | i_operand_b);
            CMD_AND:  o_result = i_operand_a & i_operand_b;
            CMD_OR:   o_result = i_operand_a | i_operand_b;
            CMD_XOR:  o_result = i_operand_a ^ i_operand_b;
            CMD_NAND: o_result = ~(i_operand_a & i_operand_b);
            CMD_CLR:  o_result = i_operand_a & ~i_operand_b;
            CMD_ORC:  o_result = i_operand_a | ~i_operand_b;
            CMD_RSUB: o_result = i_operand_b - i_operand_a;
            CMD_ADD:  o_result = i_operand_a + i_operand_b;
            CMD_SUB:  o_result = i_operand_a - i_operand_b;
            default:  o_result = i_operand_a;
        endcase
    end

endmodule

/* sv/ialu_mul.sv */
// ----------------------------------------------------------------------------
// ialu_mul
// two-stage 32x32 signed multiplier built from 16x16 partial products
// ----------------------------------------------------------------------------
module ialu_mul import ialu_pkg::*; (
    input  logic              i_clk,
    input  t_ialu_adv         i_adv,
    input  logic [WORD_W-1:0] i_operand_a,
    input  logic [WORD_W-1:0] i_operand_b,
    output logic [WORD_W-1:0] o_prod_hi,
    output logic [WORD_W-1:0] o_prod_lo
);

    logic [WORD_W-1:0] r_pp_ll, r_pp_lh, r_pp_hl, r_pp_hh;
    logic [WORD_W-1:0] r_corr_b, r_corr_c;
    logic [PROD_W-1:0] r_prod;
    logic [WORD_W-1:0] n_corr;
    logic [PROD_W-1:0] n_prod;

    // signed high word = unsigned high word minus sign-weighted operands
    assign n_corr = (i_operand_a[WORD_W-1] ? i_operand_b : '0)
                  + (i_operand_b[WORD_W-1] ? i_operand_a : '0);

    assign n_prod = {{WORD_W{1'b0}}, r_pp_ll}
                  + {{HALF_W{1'b0}}, r_pp_lh, {HALF_W{1'b0}}}
                  + {{HALF_W{1'b0}}, r_pp_hl, {HALF_W{1'b0}}}
                  + {r_pp_hh, {WORD_W{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (i_adv.s2) begin
            r_pp_ll  <= i_operand_a[HALF_W-1:0] * i_operand_b[HALF_W-1:0];
            r_pp_lh  <= i_operand_a[HALF_W-1:0] * i_operand_b[WORD_W-1:HALF_W];
            r_pp_hl  <= i_operand_a[WORD_W-1:HALF_W] * i_operand_b[HALF_W-1:0];
            r_pp_hh  <= i_operand_a[WORD_W-1:HALF_W] * i_operand_b[WORD_W-1:HALF_W];
            r_corr_b <= n_corr;
        end
        if (i_adv.s3) begin
            r_prod   <= n_prod;
            r_corr_c <= r_corr_b;
        end
    end

    assign o_prod_lo = r_prod[WORD_W-1:0];
    assign o_prod_hi = r_prod[PROD_W-1:WORD_W] - r_corr_c;

endmodule

/* sv/integer_alu_32bit.sv */
// ----------------------------------------------------------------------------
// integer_alu_32bit
// four-stage pipelined 32-bit integer alu with signed multiply
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-----------------------------------
//  input    | in        | i_valid / o_stall  | i_command, i_operand_a, i_operand_b
//  output   | out       | o_valid / i_stall  | o_result
//
//  one transfer per cycle sustained while i_stall is low; each result passes
//  every stage after its input transfer, a depth set by the partial-product
//  multiplier (operand capture, partial products and sum take one stage each,
//  sign correction and result select share the last)
//  reset is synchronous and active low and empties every stage
//  each full stage holds while the one after it is full and held, so bubbles
//  close up under an output stall before o_stall rises
//  a nop transfer is consumed at the input and never reaches the output
//
module integer_alu_32bit import ialu_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [CMD_W-1:0]  i_command,
    input  logic [WORD_W-1:0] i_operand_a,
    input  logic [WORD_W-1:0] i_operand_b,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [WORD_W-1:0] o_result
);

    // stage 1: captured operands
    logic              r_s1_valid;
    logic [CMD_W-1:0]  r_s1_cmd;
    logic [WORD_W-1:0] r_s1_a, r_s1_b;
    // stage 2: alu result, partial products in the multiplier
    logic              r_s2_valid;
    logic [CMD_W-1:0]  r_s2_cmd;
    logic [WORD_W-1:0] r_s2_alu;
    // stage 3: alu result carried, product summed in the multiplier
    logic              r_s3_valid;
    logic [CMD_W-1:0]  r_s3_cmd;
    logic [WORD_W-1:0] r_s3_alu;
    // stage 4: output register
    logic              r_s4_valid;
    logic [WORD_W-1:0] r_s4_result;

    logic              en1, en2, en3, en4;
    logic              n_s1_valid;
    logic [WORD_W-1:0] n_s2_alu;
    logic [WORD_W-1:0] n_s4_result;
    logic [WORD_W-1:0] prod_hi, prod_lo;
    t_ialu_adv         mul_adv;

    // a stage loads when it is empty or its contents move on
    assign en4 = !r_s4_valid || !i_stall;
    assign en3 = !r_s3_valid || en4;
    assign en2 = !r_s2_valid || en3;
    assign en1 = !r_s1_valid || en2;

    assign o_stall = !en1;

    // nop transfers are taken but leave a bubble
    assign n_s1_valid = i_valid && (i_command != CMD_NOP);

    assign mul_adv.s2 = en2;
    assign mul_adv.s3 = en3;

    ialu_exec u_exec (
        .i_command   (r_s1_cmd),
        .i_operand_a (r_s1_a),
        .i_operand_b (r_s1_b),
        .o_result    (n_s2_alu)
    );

    ialu_mul u_mul (
        .i_clk       (i_clk),
        .i_adv       (mul_adv),
        .i_operand_a (r_s1_a),
        .i_operand_b (r_s1_b),
        .o_prod_hi   (prod_hi),
        .o_prod_lo   (prod_lo)
    );

    // final select between multiplier words and the carried alu result
    always_comb begin
        case (r_s3_cmd)
            CMD_MULHI: n_s4_result = prod_hi;
            CMD_MULLO: n_s4_result = prod_lo;
            default:   n_s4_result = r_s3_alu;
        endcase
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else begin
            if (en1) r_s1_valid <= n_s1_valid;
            if (en2) r_s2_valid <= r_s1_valid;
            if (en3) r_s3_valid <= r_s2_valid;
            if (en4) r_s4_valid <= r_s3_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_cmd <= i_command;
            r_s1_a   <= i_operand_a;
            r_s1_b   <= i_operand_b;
        end
        if (en2) begin
            r_s2_cmd <= r_s1_cmd;
            r_s2_alu <= n_s2_alu;
        end
        if (en3) begin
            r_s3_cmd <= r_s2_cmd;
            r_s3_alu <= r_s2_alu;
        end
        if (en4) begin
            r_s4_result <= n_s4_result;
        end
    end

    assign o_valid  = r_s4_valid;
    assign o_result = r_s4_result;

endmodule

/* sv/ialu_checker.sv */
// ----------------------------------------------------------------------------
// ialu_checker
// port-level assertions on the pipelined alu, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ialu_checker import ialu_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_stall,
    input logic [CMD_W-1:0]  i_command,
    input logic [WORD_W-1:0] i_operand_a,
    input logic [WORD_W-1:0] i_operand_b,
    input logic              o_valid,
    input logic              i_stall,
    input logic [WORD_W-1:0] o_result
);

    // reset empties the pipeline
    `ASSERT_ALWAYS(a_reset_empty, i_clk,
        !i_rst_n |=> !o_valid,
        "output valid after reset")

    // a held result stays put
    `ASSERT_RST(a_out_hold, i_clk, i_rst_n,
        o_valid && i_stall |=> o_valid && $stable(o_result),
        "held result changed")

    // input backpressure only comes from an output stall
    `ASSERT_RST(a_stall_source, i_clk, i_rst_n,
        !i_stall |-> !o_stall,
        "stall without output stall")

    // an xor accepted while the output path stays free reaches the output with its value
    `ASSERT_RST(a_xor_latency, i_clk, i_rst_n,
        (i_valid && !o_stall && i_command == CMD_XOR) ##1 !i_stall ##1 !i_stall
            ##1 !i_stall |=> o_valid
            && o_result == ($past(i_operand_a, 4) ^ $past(i_operand_b, 4)),
        "xor result late or wrong")

endmodule

bind integer_alu_32bit ialu_checker u_ialu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .i_command   (i_command),
    .i_operand_a (i_operand_a),
    .i_operand_b (i_operand_b),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_result    (o_result)
);

/* dv/tb_integer_alu_32bit.sv */
// ----------------------------------------------------------------------------
// tb_integer_alu_32bit
// self-checking bench for the pipelined 32-bit integer alu: directed corner
// items per operation group, then a long random mix, with random gaps on the
// input side and random stalls on the output side; every result is compared
// in order against a behavioral model of the alu
// ----------------------------------------------------------------------------
module tb_integer_alu_32bit import ialu_pkg::*; ();

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 8;
    localparam int RANDOM_ITEMS  = 1420;
    localparam int DRAIN_CYCLES  = 16;
    localparam int RUN_LIMIT     = 5_000_000;
    localparam logic [CMD_W-1:0] CMD_MAX = {CMD_W{1'b1}};

    // one accepted operation and the word it must produce
    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] result;
    } t_alu_txn;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_valid     = 1'b0;
    logic              o_stall;
    logic [CMD_W-1:0]  i_command   = CMD_NOP;
    logic [WORD_W-1:0] i_operand_a = '0;
    logic [WORD_W-1:0] i_operand_b = '0;
    logic              o_valid;
    logic              i_stall     = 1'b0;
    logic [WORD_W-1:0] o_result;

    t_alu_txn pending_results[$];
    int       mismatch_count = 0;

    // input-side burst bookkeeping: quiet stretches send back to back
    int  send_burst_left = 0;
    bit  send_burst_quiet = 1'b0;

    integer_alu_32bit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_command   (i_command),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_result    (o_result)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // behavioral alu: the word that one operation must produce
    function automatic logic [WORD_W-1:0] alu_result_of(
        input logic [CMD_W-1:0]  cmd,
        input logic [WORD_W-1:0] a,
        input logic [WORD_W-1:0] b
    );
        logic [SHAMT_W-1:0]       shamt;
        logic signed [WORD_W-1:0] a_s;
        logic signed [WORD_W-1:0] b_s;
        logic signed [PROD_W-1:0] prod_s;
        logic [PROD_W-1:0]        prod_u;
        shamt  = b[SHAMT_W-1:0];
        a_s    = a;
        b_s    = b;
        prod_s = $signed({{WORD_W{a[WORD_W-1]}}, a}) * $signed({{WORD_W{b[WORD_W-1]}}, b});
        prod_u = {{WORD_W{1'b0}}, a} * {{WORD_W{1'b0}}, b};
        case (cmd)
            CMD_SLL:   return a << shamt;
            CMD_SRL:   return a >> shamt;
            CMD_SRA:   return a_s >>> shamt;
            CMD_SEQ:   return {{(WORD_W-1){1'b0}}, a == b};
            CMD_SNE:   return {{(WORD_W-1){1'b0}}, a != b};
            CMD_SLT:   return {{(WORD_W-1){1'b0}}, a_s < b_s};
            CMD_SLTU:  return {{(WORD_W-1){1'b0}}, a < b};
            CMD_LUI:   return a << HALF_W;
            CMD_NOR:   return ~(a | b);
            CMD_AND:   return a & b;
            CMD_OR:    return a | b;
            CMD_XOR:   return a ^ b;
            CMD_NAND:  return ~(a & b);
            CMD_CLR:   return a & ~b;
            CMD_ORC:   return a | ~b;
            CMD_RSUB:  return b - a;
            CMD_ADD:   return a + b;
            CMD_SUB:   return a - b;
            CMD_MULHI: return prod_s[PROD_W-1:WORD_W];
            CMD_MULLO: return prod_u[WORD_W-1:0];
            default:   return a;
        endcase
    endfunction

    // idle length shared by both sides: mostly none or short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(99);
        if (r < 45)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // present one operation and hold it until the transfer happens
    task automatic send_op(
        input logic [CMD_W-1:0]  cmd,
        input logic [WORD_W-1:0] a,
        input logic [WORD_W-1:0] b
    );
        int       gap;
        t_alu_txn txn;
        if (send_burst_left == 0) begin
            send_burst_quiet = ($urandom_range(3) == 0);
            send_burst_left  = $urandom_range(20, 80);
        end
        send_burst_left--;
        gap = send_burst_quiet ? 0 : idle_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_command   <= cmd;
        i_operand_a <= a;
        i_operand_b <= b;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        // a nop is swallowed at the input and owes no result
        if (cmd != CMD_NOP) begin
            txn.cmd    = cmd;
            txn.a      = a;
            txn.b      = b;
            txn.result = alu_result_of(cmd, a, b);
            pending_results.push_back(txn);
        end
    endtask

    task automatic test_no_op();
        send_op(CMD_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(CMD_ADD, 32'h0000_0001, 32'h0000_0002);
        send_op(CMD_NOP, 32'h0000_0000, 32'h0000_0000);
    endtask

    // extreme shift amounts, stray bits above the shift field, sign fill
    task automatic test_shifts();
        send_op(CMD_SLL, 32'h0000_0001, 32'h0000_001F);
        send_op(CMD_SRL, 32'h8000_0000, 32'h0000_003F);
        send_op(CMD_SRA, 32'h8000_0000, 32'h0000_001F);
        send_op(CMD_SRA, 32'h7FFF_FFFF, 32'hFFFF_FFE1);
        send_op(CMD_SLL, 32'hFFFF_FFFF, 32'hFFFF_FFE0);
    endtask

    // equality on all-ones; signed and unsigned order disagree across the sign boundary
    task automatic test_compares();
        send_op(CMD_SEQ,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(CMD_SNE,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(CMD_SLT,  32'h8000_0000, 32'h7FFF_FFFF);
        send_op(CMD_SLTU, 32'h8000_0000, 32'h7FFF_FFFF);
    endtask

    task automatic test_logic_ops();
        send_op(CMD_NOR,  32'h0000_0000, 32'h0000_0000);
        send_op(CMD_AND,  32'hFFFF_FFFF, 32'hA5A5_5A5A);
        send_op(CMD_OR,   32'hF0F0_0000, 32'h0000_0F0F);
        send_op(CMD_XOR,  32'hFFFF_FFFF, 32'h1234_5678);
        send_op(CMD_NAND, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(CMD_CLR,  32'hFFFF_FFFF, 32'h0F0F_F0F0);
        send_op(CMD_ORC,  32'h0000_0000, 32'h0000_0000);
    endtask

    // wraparound at both ends of the word
    task automatic test_add_sub();
        send_op(CMD_RSUB, 32'h0000_0001, 32'h0000_0000);
        send_op(CMD_ADD,  32'hFFFF_FFFF, 32'h0000_0001);
        send_op(CMD_SUB,  32'h0000_0000, 32'h0000_0001);
    endtask

    // high word of the signed product, low word with overflow
    task automatic test_multiply();
        send_op(CMD_MULHI, 32'h8000_0000, 32'h8000_0000);
        send_op(CMD_MULHI, 32'hFFFF_FFFF, 32'h0000_0001);
        send_op(CMD_MULLO, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    // load-upper ignores operand b; unassigned codes pass operand a
    task automatic test_load_upper_and_pass();
        send_op(CMD_LUI,                 32'hFFFF_FFFF, 32'hDEAD_BEEF);
        send_op(CMD_W'(CMD_MULLO + 1),   32'h8765_4321, 32'hFFFF_FFFF);
        send_op(CMD_MAX,                 32'hFFFF_FFFF, 32'h0000_0000);
    endtask

    function automatic logic [WORD_W-1:0] pick_operand();
        case ($urandom_range(9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            4:       return $urandom_range(0, 40);
            5:       return -$urandom_range(1, 40);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_random_mix();
        int                sent;
        int                r;
        logic [CMD_W-1:0]  cmd;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            r = $urandom_range(99);
            if (r < 4)
                cmd = CMD_NOP;
            else if (r < 12)
                cmd = CMD_W'($urandom_range(CMD_MULLO + 1, CMD_MAX));
            else
                cmd = CMD_W'($urandom_range(CMD_SLL, CMD_MULLO));
            a = pick_operand();
            b = ($urandom_range(6) == 0) ? a : pick_operand();
            send_op(cmd, a, b);
            sent++;
        end
    endtask

    // output-side stalls: clean stretches mixed with bursty stalling
    initial begin : output_stall_gen
        int len;
        forever begin
            if ($urandom_range(3) == 0) begin
                i_stall <= 1'b0;
                repeat ($urandom_range(30, 120)) @(posedge i_clk);
            end else begin
                repeat ($urandom_range(10, 40)) begin
                    i_stall <= 1'b0;
                    repeat ($urandom_range(1, 4)) @(posedge i_clk);
                    len = idle_len();
                    if (len > 0) begin
                        i_stall <= 1'b1;
                        repeat (len) @(posedge i_clk);
                    end
                end
            end
        end
    end

    // in-order compare of every result transfer
    always @(posedge i_clk) begin : result_check
        t_alu_txn want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual %h", $time, o_result);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_result !== want.result) begin
                    $display("%0t: cmd %0d a %h b %h: expected %h, actual %h",
                             $time, want.cmd, want.a, want.b, want.result, o_result);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_no_op();
        test_shifts();
        test_compares();
        test_logic_ops();
        test_add_sub();
        test_multiply();
        test_load_upper_and_pass();
        test_random_mix();
        i_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #RUN_LIMIT;
        $display("Regression FAIL");
        $finish;
    end

endmodule
